// File: rtl/core/blcs_pkg.sv
package blcs_pkg;

	localparam logic [2:0] ACT_GET    = 3'd0;
	localparam logic [2:0] ACT_INIT   = 3'd1;
	localparam logic [2:0] ACT_SHADOW = 3'd2;
	localparam logic [2:0] ACT_PUT    = 3'd3;
	localparam logic [2:0] ACT_FLUSH  = 3'd4;

	localparam logic [2:0] STS_HIT    = 3'd0;
	localparam logic [2:0] STS_MISS   = 3'd1;
	localparam logic [2:0] STS_INIT   = 3'd2;
	localparam logic [2:0] STS_WRITE  = 3'd3;
	localparam logic [2:0] STS_NOBUF  = 3'd4;
	localparam logic [2:0] STS_DONE   = 3'd5;
	localparam logic [2:0] STS_MISUSE = 3'd6;

	localparam logic REG_DEVICE_BLOCKS  = 1'b0;
	localparam logic REG_RESERVED_BLOCK = 1'b1;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_PIN_HIT,
		OP_CLAIM,
		OP_INIT,
		OP_SHADOW,
		OP_PUT,
		OP_FLUSH_WB
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] key;
		logic        unlink;
		logic        append;
	} cmd_t;

endpackage

// File: rtl/core/blcs_cell.sv
module blcs_cell #(
	parameter int ENTRIES  = 32,
	parameter int PIN_BITS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [$clog2(ENTRIES)-1:0] index,
	input  logic                       sel,
	input  logic                       we,
	input  blcs_pkg::cmd_t             cmd,
	input  logic [$clog2(ENTRIES)-1:0] rank_k,
	input  logic [$clog2(ENTRIES)-1:0] fill,
	input  logic                       tok_in,
	input  logic                       shift,
	input  logic                       tok_clr,
	output logic                       tok,
	output logic                       is_head,
	output logic                       rd_match,
	output logic [31:0]                rd_rtag,
	output logic                       rd_rvalid,
	output logic [31:0]                rd_wtag,
	output logic                       rd_wpend,
	output logic [PIN_BITS-1:0]        rd_pin,
	output logic [$clog2(ENTRIES)-1:0] rd_rank
);
	import blcs_pkg::*;

	localparam int RW = $clog2(ENTRIES);

	logic [31:0]       rtag_q;
	logic              rvalid_q;
	logic [31:0]       wtag_q;
	logic              wpend_q;
	logic [PIN_BITS-1:0] pin_q;
	logic [RW-1:0]     rank_q;
	logic              tok_q;
	logic              free;
	logic              match;

	assign free    = (pin_q == '0) && !wpend_q;
	assign match   = (rvalid_q && rtag_q == cmd.key) || (wpend_q && wtag_q == cmd.key);
	assign tok     = tok_q;
	assign is_head = free && (rank_q == '0);

	assign rd_match  = sel && match;
	assign rd_rtag   = sel ? rtag_q : '0;
	assign rd_rvalid = sel && rvalid_q;
	assign rd_wtag   = sel ? wtag_q : '0;
	assign rd_wpend  = sel && wpend_q;
	assign rd_pin    = sel ? pin_q : '0;
	assign rd_rank   = sel ? rank_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rtag_q   <= '0;
			rvalid_q <= 1'b0;
			wtag_q   <= '0;
			wpend_q  <= 1'b0;
			pin_q    <= '0;
			rank_q   <= index;
			tok_q    <= 1'b0;
		end else begin
			if (tok_clr) begin
				tok_q <= 1'b0;
			end else if (shift) begin
				tok_q <= tok_in;
			end
			if (we) begin
				case (cmd.op)
					OP_PIN_HIT: begin
						pin_q <= pin_q + PIN_BITS'(1);
					end
					OP_CLAIM: begin
						rtag_q   <= cmd.key;
						rvalid_q <= 1'b1;
						pin_q    <= PIN_BITS'(1);
					end
					OP_INIT: begin
						rtag_q   <= '0;
						rvalid_q <= 1'b0;
						wtag_q   <= cmd.key;
						wpend_q  <= 1'b1;
						pin_q    <= PIN_BITS'(1);
					end
					OP_SHADOW: begin
						wtag_q  <= cmd.key;
						wpend_q <= 1'b1;
					end
					OP_PUT: begin
						pin_q <= pin_q - PIN_BITS'(1);
					end
					OP_FLUSH_WB: begin
						wpend_q  <= 1'b0;
						rvalid_q <= 1'b1;
						rtag_q   <= wtag_q;
					end
					default: begin
					end
				endcase
				if (cmd.append) begin
					rank_q <= fill;
				end
			end else if (cmd.unlink && free && rank_q > rank_k) begin
				rank_q <= rank_q - RW'(1);
			end
		end
	end

endmodule

// File: rtl/core/block_cache_lru_pin_shadow.sv
// Tag and replacement engine of a device block cache with pin counts.
// Items enter on the in channel (in_valid/in_ready, fields action,
// block_number, entry); results leave on the out channel (out_valid/out_ready,
// fields status, entry_index, device_block, last). An item yields one or more
// results, and last marks its final one. Registers are written through
// cfg_wr_en, cfg_index and cfg_data; the user must do so only while the
// block is idle, which the block does not enforce. Each entry is a cell in
// a row; a token passes from cell to cell, one cell per cycle unless a
// write-back waits on the output, for tag lookup and for the flush walk.
// Shadow, put and misuse need no walk. Get and init search the row and, on
// a miss with a full cache, flush before claiming an entry. A new item is
// taken once the previous one has placed its final result in the output
// register. When the receiver stalls, the result stays in the output
// register and the walk holds its place until the transfer happens.
// Reset empties the cache: all entries are unpinned, clean and free, in index
// order from least to most recently used, device_blocks is all ones and
// reserved_block is zero.
module block_cache_lru_pin_shadow #(
	parameter int ENTRIES  = 32,
	parameter int PIN_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic [31:0] block_number,
	input  logic [4:0]  entry,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [4:0]  entry_index,
	output logic [31:0] device_block,
	output logic        last,
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	import blcs_pkg::*;

	localparam int IW  = $clog2(ENTRIES);
	localparam int FCW = $clog2(ENTRIES + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_SEARCH,
		S_CLAIM,
		S_FLUSH,
		S_DONE
	} state_t;

	state_t           st_q, st_d;
	logic [2:0]       act_q;
	logic [31:0]      blk_q;
	logic [4:0]       ent_q;
	logic             flushed_q, flushed_d;
	logic [31:0]      dev_q;
	logic [31:0]      rsv_q;
	logic [FCW-1:0]   fcnt_q;
	logic             out_valid_q;
	logic [2:0]       status_q;
	logic [4:0]       entry_index_q;
	logic [31:0]      device_block_q;
	logic             last_q;

	logic [ENTRIES-1:0] tok, head, dec, sel, tgt, tok_chain;
	logic [ENTRIES-1:0] c_match, c_rvalid, c_wpend;
	logic [31:0]        c_rtag [ENTRIES];
	logic [31:0]        c_wtag [ENTRIES];
	logic [PIN_BITS-1:0] c_pin [ENTRIES];
	logic [IW-1:0]      c_rank [ENTRIES];

	logic                rd_match, rd_rvalid, rd_wpend;
	logic [31:0]         rd_rtag, rd_wtag;
	logic [PIN_BITS-1:0] rd_pin;
	logic [IW-1:0]       rd_rank;
	logic [IW-1:0]       tok_idx, head_idx;

	logic          can_emit, emit, e_last;
	logic [2:0]    e_sts;
	logic [IW-1:0] e_idx;
	logic [31:0]   e_blk;
	cmd_t          cmd;
	logic [IW-1:0] rank_k;
	logic          tok_start, tok_adv, tok_clr, tok_last, ent_ok, bad_shadow;

	assign in_ready     = (st_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign entry_index  = entry_index_q;
	assign device_block = device_block_q;
	assign last         = last_q;
	assign can_emit     = !out_valid_q || out_ready;
	assign tok_last     = tok[ENTRIES-1];
	assign ent_ok       = int'(ent_q) < ENTRIES;

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			dec[i] = (st_q == S_START) && (int'(ent_q) == i);
		end
	end
	assign sel = tok | dec;

	assign tok_chain[0] = tok_start;
	for (genvar g = 1; g < ENTRIES; g++) begin : g_chain
		assign tok_chain[g] = tok[g-1];
	end

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		blcs_cell #(
			.ENTRIES  (ENTRIES),
			.PIN_BITS (PIN_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.index     (IW'(g)),
			.sel       (sel[g]),
			.we        (tgt[g]),
			.cmd       (cmd),
			.rank_k    (rank_k),
			.fill      (IW'(fcnt_q)),
			.tok_in    (tok_chain[g]),
			.shift     (tok_adv || tok_start),
			.tok_clr   (tok_clr),
			.tok       (tok[g]),
			.is_head   (head[g]),
			.rd_match  (c_match[g]),
			.rd_rtag   (c_rtag[g]),
			.rd_rvalid (c_rvalid[g]),
			.rd_wtag   (c_wtag[g]),
			.rd_wpend  (c_wpend[g]),
			.rd_pin    (c_pin[g]),
			.rd_rank   (c_rank[g])
		);
	end

	always_comb begin
		rd_match  = |c_match;
		rd_rvalid = |c_rvalid;
		rd_wpend  = |c_wpend;
		rd_rtag   = '0;
		rd_wtag   = '0;
		rd_pin    = '0;
		rd_rank   = '0;
		tok_idx   = '0;
		head_idx  = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			rd_rtag = rd_rtag | c_rtag[i];
			rd_wtag = rd_wtag | c_wtag[i];
			rd_pin  = rd_pin | c_pin[i];
			rd_rank = rd_rank | c_rank[i];
			if (tok[i]) begin
				tok_idx = tok_idx | IW'(i);
			end
			if (head[i]) begin
				head_idx = head_idx | IW'(i);
			end
		end
	end

	assign bad_shadow = !ent_ok || rd_pin == '0 || rd_wpend ||
		(blk_q != rsv_q && rd_rvalid && rd_rtag == blk_q);

	always_comb begin
		st_d       = st_q;
		flushed_d  = flushed_q;
		emit       = 1'b0;
		e_sts      = STS_MISUSE;
		e_idx      = '0;
		e_blk      = '0;
		e_last     = 1'b1;
		tgt        = '0;
		cmd.op     = OP_NOP;
		cmd.key    = blk_q;
		cmd.unlink = 1'b0;
		cmd.append = 1'b0;
		rank_k     = rd_rank;
		tok_start  = 1'b0;
		tok_adv    = 1'b0;
		tok_clr    = 1'b0;
		case (st_q)
			S_IDLE: begin
				if (in_valid) begin
					st_d      = S_START;
					flushed_d = 1'b0;
				end
			end
			S_START: begin
				if ((act_q <= ACT_SHADOW && blk_q >= dev_q) || act_q > ACT_FLUSH) begin
					if (can_emit) begin
						emit = 1'b1;
						st_d = S_IDLE;
					end
				end else begin
					case (act_q)
						ACT_GET, ACT_INIT: begin
							tok_start = 1'b1;
							st_d      = S_SEARCH;
						end
						ACT_FLUSH: begin
							tok_start = 1'b1;
							st_d      = S_FLUSH;
						end
						ACT_SHADOW: begin
							if (can_emit) begin
								emit = 1'b1;
								st_d = S_IDLE;
								if (!bad_shadow) begin
									e_sts  = STS_DONE;
									e_idx  = IW'(ent_q);
									tgt    = dec;
									cmd.op = OP_SHADOW;
								end
							end
						end
						ACT_PUT: begin
							if (can_emit) begin
								emit = 1'b1;
								st_d = S_IDLE;
								if (ent_ok && rd_pin != '0) begin
									e_sts      = STS_DONE;
									e_idx      = IW'(ent_q);
									tgt        = dec;
									cmd.op     = OP_PUT;
									cmd.append = (rd_pin == PIN_BITS'(1)) && !rd_wpend;
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_SEARCH: begin
				if (rd_match) begin
					if (can_emit) begin
						emit    = 1'b1;
						tok_clr = 1'b1;
						st_d    = S_IDLE;
						if (act_q == ACT_GET) begin
							if (!(&rd_pin)) begin
								e_sts      = STS_HIT;
								e_idx      = tok_idx;
								tgt        = tok;
								cmd.op     = OP_PIN_HIT;
								cmd.unlink = (rd_pin == '0) && !rd_wpend;
							end
						end else if (rd_pin == '0) begin
							e_sts      = STS_INIT;
							e_idx      = tok_idx;
							tgt        = tok;
							cmd.op     = OP_INIT;
							cmd.unlink = !rd_wpend;
						end
					end
				end else begin
					tok_adv = 1'b1;
					if (tok_last) begin
						st_d = S_CLAIM;
					end
				end
			end
			S_CLAIM: begin
				if (fcnt_q == '0) begin
					if (flushed_q) begin
						if (can_emit) begin
							emit  = 1'b1;
							e_sts = STS_NOBUF;
							st_d  = S_IDLE;
						end
					end else begin
						tok_start = 1'b1;
						flushed_d = 1'b1;
						st_d      = S_FLUSH;
					end
				end else if (can_emit) begin
					emit       = 1'b1;
					st_d       = S_IDLE;
					tgt        = head;
					cmd.unlink = 1'b1;
					rank_k     = '0;
					e_idx      = head_idx;
					if (act_q == ACT_GET) begin
						cmd.op = OP_CLAIM;
						e_sts  = STS_MISS;
						e_blk  = blk_q;
					end else begin
						cmd.op = OP_INIT;
						e_sts  = STS_INIT;
					end
				end
			end
			S_FLUSH: begin
				if (rd_pin == '0 && rd_wpend) begin
					if (can_emit) begin
						emit       = 1'b1;
						e_sts      = STS_WRITE;
						e_idx      = tok_idx;
						e_blk      = rd_wtag;
						e_last     = 1'b0;
						tgt        = tok;
						cmd.op     = OP_FLUSH_WB;
						cmd.append = 1'b1;
						tok_adv    = 1'b1;
						if (tok_last) begin
							st_d = (act_q == ACT_FLUSH) ? S_DONE : S_CLAIM;
						end
					end
				end else begin
					tok_adv = 1'b1;
					if (tok_last) begin
						st_d = (act_q == ACT_FLUSH) ? S_DONE : S_CLAIM;
					end
				end
			end
			S_DONE: begin
				if (can_emit) begin
					emit  = 1'b1;
					e_sts = STS_DONE;
					st_d  = S_IDLE;
				end
			end
			default: begin
				st_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			flushed_q   <= 1'b0;
			dev_q       <= '1;
			rsv_q       <= '0;
			fcnt_q      <= FCW'(ENTRIES);
			out_valid_q <= 1'b0;
		end else begin
			st_q      <= st_d;
			flushed_q <= flushed_d;
			fcnt_q    <= fcnt_q - FCW'(cmd.unlink) + FCW'(cmd.append);
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_DEVICE_BLOCKS:  dev_q <= cfg_data;
					REG_RESERVED_BLOCK: rsv_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			act_q <= action;
			blk_q <= block_number;
			ent_q <= entry;
		end
		if (emit) begin
			status_q       <= e_sts;
			entry_index_q  <= 5'(e_idx);
			device_block_q <= e_blk;
			last_q         <= e_last;
		end
	end

	a_token_single: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok))
		else $error("more than one cell holds the walk token");

	a_idle_no_token: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_IDLE |-> tok == '0)
		else $error("walk token left behind after an item completed");

	a_free_count: assert property (@(posedge clk) disable iff (!arst_n)
		fcnt_q <= FCW'(ENTRIES) && ((fcnt_q != '0) == (|head)) && $onehot0(head))
		else $error("free count and free list head disagree");

endmodule
